// ===== rtl/core/spmq_pkg.sv =====
// Shared types, constants and codes for the strict priority multi-queue.
`timescale 1ns / 1ps
package spmq_pkg;

  localparam int LEVELS = 3;
  localparam int DEPTH  = 16;

  // Field widths fixed by the request and response formats
  localparam int LVL_W = 2;
  localparam int PAY_W = 32;
  localparam int ST_W  = 2;

  // Widths derived from the queue geometry
  localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOTS  = LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  // Request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Response status codes
  localparam logic [ST_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [ST_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [LVL_W-1:0] priority_level;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [LVL_W-1:0] served_level;
    logic [PAY_W-1:0] served_payload;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;     // capture the accepted request
    logic commit_enq;   // write the entry, advance tail, bump count
    logic commit_deq;   // read the head, advance head, drop count
    logic load_plain;   // load an enqueue, empty or full response
    logic load_served;  // load a served response from the read data
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_deq;     // held request is a dequeue
    logic any_ready;  // at least one queue holds an entry
  } dp_stat_t;

endpackage

// ===== rtl/core/strict_priority_multi_queue.sv =====
// Top level of the three-level strict priority multi-queue.
//
//   channel   signals                         payload
//   request   req_valid / req_ready           req_data  (req_t)
//   response  rsp_valid / rsp_ready           rsp_data  (rsp_t)
//
// An enqueue, a rejected enqueue or an empty dequeue loads its response once
// the response slot is free; a served dequeue first does the registered read
// of the entry memory and then loads its response once the slot is free. The
// state machine handles one request at a time, so a new request is accepted
// only after the response of the previous one has been loaded.
// Reset empties every queue at once; memory contents are not cleared.
// A stalled response holds in its register while the next request is taken.
`timescale 1ns / 1ps
module strict_priority_multi_queue import spmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spmq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_data (rsp_data)
  );

endmodule

// ===== rtl/core/spmq_datapath.sv =====
// Queue pointers, fill counts, entry memory and response register.
`timescale 1ns / 1ps
module spmq_datapath import spmq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output rsp_t     rsp_data
);

  req_t             req_q;
  logic [PTR_W-1:0] heads  [LEVELS];
  logic [PTR_W-1:0] tails  [LEVELS];
  logic [CNT_W-1:0] counts [LEVELS];
  logic [PAY_W-1:0] mem    [SLOTS];
  logic [PAY_W-1:0] rd_data;
  logic [LIDX_W-1:0] sel_q;
  rsp_t             rsp_q;

  logic              lvl_ok;
  logic [LIDX_W-1:0] enq_idx;
  logic              enq_ok;
  logic              any_ready;
  logic [LIDX_W-1:0] sel;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Check the enqueue target
  always_comb begin
    lvl_ok  = ({1'b0, req_q.priority_level} < (LVL_W + 1)'(LEVELS));
    enq_idx = lvl_ok ? LIDX_W'(req_q.priority_level) : '0;
    enq_ok  = lvl_ok && (counts[enq_idx] < CNT_W'(DEPTH));
  end

  // Pick the highest-priority non-empty queue
  always_comb begin
    any_ready = 1'b0;
    sel       = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        any_ready = 1'b1;
        sel       = LIDX_W'(i);
      end
    end
  end

  assign wr_addr = ADDR_W'(enq_idx) * ADDR_W'(DEPTH) + ADDR_W'(tails[enq_idx]);
  assign rd_addr = ADDR_W'(sel) * ADDR_W'(DEPTH) + ADDR_W'(heads[sel]);

  assign stat.is_deq    = (req_q.req_type == REQ_DEQ);
  assign stat.any_ready = any_ready;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_data;
    end
  end

  // Advance pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else if (cmd.commit_enq && enq_ok) begin
      tails[enq_idx]  <= next_slot(tails[enq_idx]);
      counts[enq_idx] <= counts[enq_idx] + CNT_W'(1);
    end else if (cmd.commit_deq) begin
      heads[sel]  <= next_slot(heads[sel]);
      counts[sel] <= counts[sel] - CNT_W'(1);
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.commit_enq && enq_ok) begin
      mem[wr_addr] <= req_q.payload;
    end
    if (cmd.commit_deq) begin
      rd_data <= mem[rd_addr];
      sel_q   <= sel;
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (cmd.load_served) begin
      rsp_q.status         <= ST_SERVED;
      rsp_q.served_level   <= LVL_W'(sel_q);
      rsp_q.served_payload <= rd_data;
    end else if (cmd.load_plain) begin
      priority if (stat.is_deq) begin
        rsp_q.status <= ST_EMPTY;
      end else if (enq_ok) begin
        rsp_q.status <= ST_ENQUEUED;
      end else begin
        rsp_q.status <= ST_FULL;
      end
      rsp_q.served_level   <= '0;
      rsp_q.served_payload <= '0;
    end
  end

  assign rsp_data = rsp_q;

endmodule

// ===== rtl/core/spmq_ctrl.sv =====
// Request sequencing state machine and response valid flag.
`timescale 1ns / 1ps
module spmq_ctrl import spmq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_deq && stat.any_ready) begin
          cmd.commit_deq = 1'b1;
          state_next     = S_RDWAIT;
        end else if (out_free) begin
          cmd.commit_enq = !stat.is_deq;
          cmd.load_plain = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RDWAIT: begin
        if (out_free) begin
          cmd.load_served = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state and track the response slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_plain || cmd.load_served) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/spmq_checker.sv =====
// Port-level checks for the strict priority multi-queue, bound to the top.
`timescale 1ns / 1ps
module spmq_checker import spmq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // A served response names an existing level
  a_served_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_SERVED
      |-> {1'b0, rsp_data.served_level} < (LVL_W + 1)'(LEVELS))
    else $error("served level out of range");

  // Nothing served means zero level and payload
  a_unserved_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_SERVED
      |-> rsp_data.served_level == '0 && rsp_data.served_payload == '0)
    else $error("unserved response carries data");

  // One request in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // An enqueue to a level beyond the last is rejected once the response slot frees
  a_bad_level: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.req_type == REQ_ENQ
      && {1'b0, req_data.priority_level} >= (LVL_W + 1)'(LEVELS)
      |=> (!rsp_valid || rsp_ready)[->1] ##1
          (rsp_valid && rsp_data.status == ST_FULL))
    else $error("bad level not rejected");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
